// ===== rtl/imhd_pkg.sv =====
`default_nettype none

package imhd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int DATA_W      = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int LEAD_W      = $clog2(MAX_WIDTH + 3);
    localparam int CFG_WIDTH_W = 13;
    localparam int ROW_W       = 16;
    localparam int BANKS       = 4;
    localparam int BANK_W      = $clog2(BANKS);
    localparam int RES_DEPTH   = 3;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int WIN_SIZE    = 9;
    localparam int WIN_CENTER  = 4;
    localparam int FILL_STEPS  = 8;

    localparam int unsigned FILL_ORDER [FILL_STEPS] = '{1, 3, 5, 7, 0, 2, 6, 8};

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MARKER = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] texel_value;
        logic              is_flush;
    } t_texel_req;

    typedef struct packed {
        logic [DATA_W-1:0] filled_value;
        logic              last_texel;
    } t_texel_res;

    typedef logic [WIN_SIZE-1:0][DATA_W-1:0] t_window;

    typedef struct packed {
        t_window             win;
        logic [WIN_SIZE-1:0] present;
        logic [DATA_W-1:0]   marker;
    } t_fill_in;

endpackage

`default_nettype wire

// ===== rtl/imhd_ram.sv =====
`default_nettype none

module imhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== rtl/imhd_fill.sv =====
`default_nettype none

module imhd_fill (
    input  wire imhd_pkg::t_fill_in        i_fill,
    output logic [imhd_pkg::DATA_W-1:0]    o_value
);

    import imhd_pkg::*;

    logic [DATA_W-1:0] value;

    // scan backward so the earliest source in priority order wins
    always_comb begin
        value = i_fill.win[WIN_CENTER];
        if (i_fill.win[WIN_CENTER] == i_fill.marker) begin
            for (int k = FILL_STEPS - 1; k >= 0; k--) begin
                if (i_fill.present[FILL_ORDER[k]] &&
                    (i_fill.win[FILL_ORDER[k]] != i_fill.marker)) begin
                    value = i_fill.win[FILL_ORDER[k]];
                end
            end
        end
    end

    assign o_value = value;

endmodule

`default_nettype wire

// ===== rtl/index_map_hole_dilation.sv =====
`default_nettype none

// One hole-filling dilation pass over an index map streamed in raster order.
// A texel equal to the invalid marker takes the first valid original
// neighbor (above, left, right, below, then the four diagonals in raster
// order); other texels pass unchanged. One request is taken per clock while
// o_stall is low. A result leaves one row plus one texel after its texel
// enters, so after the last texel of an image the caller sends flush requests
// (or more data, which is dropped) to drain the remaining results; each such
// request yields one result until last_texel is seen. A result passes through
// the window stage and the result queue. Four row banks of MAX_WIDTH words
// each take one texel write and two column reads per clock, which sets the rate.
module index_map_hole_dilation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire imhd_pkg::t_texel_req              i_req,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output imhd_pkg::t_texel_res                   o_res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [imhd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [imhd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [imhd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    import imhd_pkg::*;

    typedef struct packed {
        logic              has_up;
        logic              has_down;
        logic              has_left;
        logic              has_right;
        logic              last;
        logic [BANK_W-1:0] bank_up;
        logic [BANK_W-1:0] bank_mid;
        logic [BANK_W-1:0] bank_dn;
        logic              byp_c;
        logic              byp_r;
        logic [BANK_W-1:0] byp_bank;
        logic [DATA_W-1:0] byp_data;
    } t_win_ctl;

    logic [CFG_WIDTH_W-1:0] r_cfg_width;
    logic [ROW_W-1:0]       r_cfg_height;
    logic [DATA_W-1:0]      r_cfg_marker;

    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [LEAD_W-1:0] r_lead,    n_lead;

    logic              r_b_valid;
    t_win_ctl          r_b;
    logic [DATA_W-1:0] r_left [3];

    t_texel_res             r_fifo [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count;

    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               cfg_wr;
    logic               acc;
    logic               done;
    logic               done_n;
    logic               st;
    logic               emit;
    logic               col_last_in;
    logic               row_last_in;
    logic               col_last_out;
    logic               row_last_out;
    logic               last;
    logic [LEAD_W-1:0]  lead_n;
    logic [COL_W-1:0]   rd_col_r;
    logic [RES_CNT_W:0] occ;
    logic               push;
    logic               pop;

    logic [DATA_W-1:0]  ram_qa [BANKS];
    logic [DATA_W-1:0]  ram_qb [BANKS];
    logic [BANK_W-1:0]  row_bank [3];
    logic [DATA_W-1:0]  col_c [3];
    logic [DATA_W-1:0]  col_r [3];
    t_fill_in           fill_in;
    logic [DATA_W-1:0]  fill_value;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_W'(1024);
            r_cfg_height <= ROW_W'(1024);
            r_cfg_marker <= '1;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_WIDTH:  r_cfg_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT: r_cfg_height <= pwdata[ROW_W-1:0];
                REG_MARKER: r_cfg_marker <= pwdata[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_WIDTH:  prdata = CFG_DATA_W'(r_cfg_width);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_cfg_height);
            REG_MARKER: prdata = CFG_DATA_W'(r_cfg_marker);
            default:    prdata = '0;
        endcase
    end

    // clamp geometry
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = WIDTH_W'(r_cfg_width);
        end
        h_eff = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
    end

    // request stage: position tracking and emit decision
    assign acc          = i_valid && !o_stall;
    assign col_last_in  = r_in_col  == COL_W'(w_eff - WIDTH_W'(1));
    assign row_last_in  = r_in_row  == h_eff - ROW_W'(1);
    assign col_last_out = r_out_col == COL_W'(w_eff - WIDTH_W'(1));
    assign row_last_out = r_out_row == h_eff - ROW_W'(1);
    assign last         = col_last_out && row_last_out;
    assign done         = r_in_row >= h_eff;
    assign st           = acc && !i_req.is_flush && !done;
    assign done_n       = done || (st && col_last_in && row_last_in);
    assign lead_n       = r_lead + LEAD_W'(st);
    assign emit         = acc && ((lead_n >= LEAD_W'(w_eff) + LEAD_W'(2)) || done_n);
    assign rd_col_r     = r_out_col + COL_W'(1);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = lead_n - LEAD_W'(emit);
        if (st) begin
            if (col_last_in) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (emit) begin
            if (col_last_out) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
        if (emit && last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
            r_b_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b.has_up    <= r_out_row != '0;
        r_b.has_down  <= !row_last_out;
        r_b.has_left  <= r_out_col != '0;
        r_b.has_right <= !col_last_out;
        r_b.last      <= last;
        r_b.bank_up   <= r_out_row[BANK_W-1:0] - BANK_W'(1);
        r_b.bank_mid  <= r_out_row[BANK_W-1:0];
        r_b.bank_dn   <= r_out_row[BANK_W-1:0] + BANK_W'(1);
        r_b.byp_c     <= st && (r_in_col == r_out_col);
        r_b.byp_r     <= st && (r_in_col == rd_col_r);
        r_b.byp_bank  <= r_in_row[BANK_W-1:0];
        r_b.byp_data  <= i_req.texel_value;
    end

    // row banks
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        imhd_ram #(
            .WIDTH(DATA_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .i_clk    (i_clk),
            .i_we     (st && (r_in_row[BANK_W-1:0] == BANK_W'(b))),
            .i_waddr  (r_in_col),
            .i_wdata  (i_req.texel_value),
            .i_raddr_a(r_out_col),
            .i_raddr_b(rd_col_r),
            .o_rdata_a(ram_qa[b]),
            .o_rdata_b(ram_qb[b])
        );
    end

    // window stage
    always_comb begin
        row_bank[0] = r_b.bank_up;
        row_bank[1] = r_b.bank_mid;
        row_bank[2] = r_b.bank_dn;
        for (int r = 0; r < 3; r++) begin
            col_c[r] = (r_b.byp_c && (r_b.byp_bank == row_bank[r])) ?
                       r_b.byp_data : ram_qa[row_bank[r]];
            col_r[r] = (r_b.byp_r && (r_b.byp_bank == row_bank[r])) ?
                       r_b.byp_data : ram_qb[row_bank[r]];
        end
        for (int r = 0; r < 3; r++) begin
            fill_in.win[3*r]     = r_left[r];
            fill_in.win[3*r + 1] = col_c[r];
            fill_in.win[3*r + 2] = col_r[r];
        end
        for (int k = 0; k < WIN_SIZE; k++) begin
            fill_in.present[k] = ((k / 3) != 0 || r_b.has_up) &&
                                 ((k / 3) != 2 || r_b.has_down) &&
                                 ((k % 3) != 0 || r_b.has_left) &&
                                 ((k % 3) != 2 || r_b.has_right);
        end
        fill_in.marker = r_cfg_marker;
    end

    imhd_fill u_fill (
        .i_fill (fill_in),
        .o_value(fill_value)
    );

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_left[r] <= col_c[r];
            end
        end
    end

    // result queue
    assign push    = r_b_valid;
    assign pop     = o_valid && !i_stall;
    assign o_valid = r_count != '0;
    assign o_res   = r_fifo[r_rd_ptr];
    assign occ     = (RES_CNT_W + 1)'(r_count) + (RES_CNT_W + 1)'(r_b_valid);
    assign o_stall = occ >= (RES_CNT_W + 1)'(RES_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr].filled_value <= fill_value;
            r_fifo[r_wr_ptr].last_texel   <= r_b.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ?
                            '0 : r_wr_ptr + RES_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ?
                            '0 : r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= r_count + RES_CNT_W'(push) - RES_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_count < RES_CNT_W'(RES_DEPTH)))
        else $error("result queue overflow");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == RES_CNT_W'(RES_DEPTH)) |-> o_stall)
        else $error("full result queue without stall");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_lead == '0 && r_in_row == '0 && r_out_row == '0 &&
                            r_in_col == '0 && r_out_col == '0))
        else $error("position counters not cleared after last texel");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_b_valid && r_b.last))
        else $error("last texel not forwarded to window stage");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import imhd_pkg::*;

    localparam int          RING_DEPTH  = 2 * MAX_WIDTH + 4;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          MODE_ITEMS  = 600;
    localparam int unsigned FILL_RANK [8] = '{1, 3, 5, 7, 0, 2, 6, 8};

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    t_texel_req              i_req   = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_texel_res              o_res;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr   = '0;
    logic [CFG_DATA_W-1:0]   pwdata  = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    index_map_hole_dilation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_texel_req  texel_reqs [$];
    t_texel_res  filled_expect [$];

    logic [12:0] cfg_width;
    logic [15:0] cfg_height;
    logic [31:0] cfg_marker;
    logic [31:0] texel_ring [RING_DEPTH];
    longint unsigned in_col, in_row, out_col, out_row;

    int          idle_mode;
    int          fail_count;
    int          req_count;
    int          result_count;
    int          image_count;
    int          cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic clear_positions();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_filled(input t_texel_req req);
        longint unsigned w, h, total, stored, o, pos;
        logic [31:0]     win [9];
        bit              present [9];
        logic [31:0]     filled;
        bit              found;
        int              dr, dc, p;
        t_texel_res      res;
        w = 64'(cfg_width);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (cfg_height == 16'd0) ? 64'd1 : 64'(cfg_height);
        total = w * h;
        o = out_row * w + out_col;
        if (o >= total) begin
            clear_positions();
            o = 0;
        end
        stored = in_row * w + in_col;
        if (stored > total) stored = total;
        if (!req.is_flush && stored < total) begin
            texel_ring[stored % RING_DEPTH] = req.texel_value;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            stored++;
        end
        if (!(stored >= o + w + 2 || stored == total)) return;
        for (int k = 0; k < 9; k++) begin
            dr = k / 3 - 1;
            dc = k % 3 - 1;
            present[k] = (dr >= 0 || out_row > 0) && (dr <= 0 || out_row + 1 < h) &&
                         (dc >= 0 || out_col > 0) && (dc <= 0 || out_col + 1 < w);
            win[k] = '0;
            if (present[k]) begin
                pos = o;
                if (dr < 0) pos -= w;
                if (dr > 0) pos += w;
                if (dc < 0) pos -= 1;
                if (dc > 0) pos += 1;
                win[k] = texel_ring[pos % RING_DEPTH];
            end
        end
        filled = win[4];
        found  = 1'b0;
        if (filled == cfg_marker) begin
            for (int j = 0; j < 8; j++) begin
                p = FILL_RANK[j];
                if (!found && present[p] && win[p] != cfg_marker) begin
                    filled = win[p];
                    found  = 1'b1;
                end
            end
        end
        res.filled_value = filled;
        res.last_texel   = (o + 1 == total);
        filled_expect.insert(filled_expect.size(), res);
        if (o + 1 == total) begin
            clear_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            0:       return $urandom_range(99) < 26;
            1:       return $urandom_range(99) < 60;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (idle_mode)
            0:       return $urandom_range(99) < 60;
            1:       return $urandom_range(99) < 26;
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_filled(i_req);
                req_count++;
            end
            if (!i_valid || !o_stall) begin
                if (texel_reqs.size() != 0 && !sender_gap()) begin
                    i_valid <= 1'b1;
                    i_req   <= texel_reqs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_texel_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (filled_expect.size() == 0) begin
                    report_mismatch("unexpected result", o_res.filled_value, '0);
                end else begin
                    want = filled_expect.pop_front();
                    if (o_res.filled_value !== want.filled_value)
                        report_mismatch("filled_value", o_res.filled_value,
                                        want.filled_value);
                    if (o_res.last_texel !== want.last_texel)
                        report_mismatch("last_texel", 32'(o_res.last_texel),
                                        32'(want.last_texel));
                end
            end
            i_stall <= receiver_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("index_map_hole_dilation verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (texel_reqs.size() != 0 || i_valid || filled_expect.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask, got;
        mask = (idx == REG_WIDTH) ? 32'h0000_1FFF :
               (idx == REG_HEIGHT) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready !== 1'b1) report_mismatch("pready", 32'(pready), 32'd1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== (value & mask)) report_mismatch("register readback", got, value & mask);
        case (idx)
            REG_WIDTH:  cfg_width  = value[12:0];
            REG_HEIGHT: cfg_height = value[15:0];
            default:    cfg_marker = value;
        endcase
    endtask

    task automatic set_geometry(input logic [12:0] w, input logic [15:0] h,
                                input logic [31:0] marker);
        wait_idle();
        apb_write(REG_WIDTH, {19'd0, w});
        apb_write(REG_HEIGHT, {16'd0, h});
        apb_write(REG_MARKER, marker);
    endtask

    function automatic t_texel_req texel(input logic [31:0] value, input logic flush);
        t_texel_req r;
        r.texel_value = value;
        r.is_flush    = flush;
        return r;
    endfunction

    task automatic add_req(input t_texel_req r);
        texel_reqs.insert(texel_reqs.size(), r);
    endtask

    function automatic int drain_count();
        int w, h, total;
        w = (cfg_width < 13'd1) ? 1 :
            (cfg_width > 13'(MAX_WIDTH)) ? MAX_WIDTH : int'(cfg_width);
        h = (cfg_height == 16'd0) ? 1 : int'(cfg_height);
        total = w * h;
        return (w + 1 < total - 1) ? w + 1 : total - 1;
    endfunction

    task automatic push_drain(output int pushed);
        int n;
        n = drain_count();
        for (int i = 0; i < n; i++)
            add_req(texel($urandom, 1'($urandom_range(1))));
        pushed = n;
    endtask

    task automatic random_image(input bit force_pause, output int pushed);
        logic [12:0] w_reg;
        logic [15:0] h_reg;
        logic [31:0] marker, value;
        int          w, h, total, hole_pct, drained, pause_at;
        pushed = 0;
        if (image_count == 0 || $urandom_range(9) != 0) begin
            w_reg = ($urandom_range(99) < 8)  ? 13'd0 :
                    ($urandom_range(99) < 70) ? 13'($urandom_range(8, 1)) :
                                                13'($urandom_range(40, 9));
            h_reg = ($urandom_range(99) < 8) ? 16'd0 : 16'($urandom_range(8, 1));
            case ($urandom_range(2))
                0:       marker = 32'h0000_0000;
                1:       marker = 32'hFFFF_FFFF;
                default: marker = $urandom;
            endcase
            set_geometry(w_reg, h_reg, marker);
        end
        w = (cfg_width == 13'd0) ? 1 : int'(cfg_width);
        h = (cfg_height == 16'd0) ? 1 : int'(cfg_height);
        total = w * h;
        hole_pct = $urandom_range(90, 10);
        pause_at = (force_pause || $urandom_range(9) == 0) ? total / 2 : -1;
        if ($urandom_range(4) == 0) add_req(texel($urandom, 1'b1));
        for (int t = 0; t < total; t++) begin
            if ($urandom_range(19) == 0) add_req(texel($urandom, 1'b1));
            if ($urandom_range(99) < hole_pct) value = cfg_marker;
            else if ($urandom_range(9) == 0) value = 32'h0000_0000;
            else if ($urandom_range(9) == 0) value = 32'hFFFF_FFFF;
            else value = $urandom;
            add_req(texel(value, 1'b0));
            if (t == pause_at) wait_idle();
        end
        push_drain(drained);
        pushed = total + drained;
        image_count++;
    endtask

    initial begin
        int pushed, mode_items;
        for (int i = 0; i < RING_DEPTH; i++) texel_ring[i] = '0;
        cfg_width    = 13'd1024;
        cfg_height   = 16'd1024;
        cfg_marker   = 32'hFFFF_FFFF;
        clear_positions();
        idle_mode    = 0;
        fail_count   = 0;
        req_count    = 0;
        result_count = 0;
        image_count  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_geometry(13'd3, 16'd3, 32'hFFFF_FFFF);
        add_req(texel(32'h1234_5678, 1'b1));
        add_req(texel(32'hFFFF_FFFF, 1'b0));
        add_req(texel(32'h0000_0005, 1'b0));
        add_req(texel(32'hFFFF_FFFF, 1'b0));
        add_req(texel(32'hFFFF_FFFF, 1'b0));
        add_req(texel(32'hDEAD_BEEF, 1'b1));
        add_req(texel(32'hFFFF_FFFF, 1'b0));
        add_req(texel(32'h0000_0007, 1'b0));
        add_req(texel(32'h0000_0000, 1'b0));
        add_req(texel(32'hFFFF_FFFF, 1'b0));
        add_req(texel(32'hFFFF_FFFE, 1'b0));
        add_req(texel(32'h0000_0000, 1'b1));
        add_req(texel(32'hFFFF_FFFF, 1'b1));
        add_req(texel(32'hAAAA_5555, 1'b0));
        add_req(texel(32'h5555_AAAA, 1'b0));
        image_count++;
        set_geometry(13'd0, 16'd0, 32'h0000_0000);
        add_req(texel(32'h0000_0000, 1'b0));
        add_req(texel(32'h0000_0005, 1'b0));
        image_count += 2;

        for (int mode = 0; mode < 3; mode++) begin
            wait_idle();
            idle_mode  = mode;
            mode_items = 0;
            while (mode_items < MODE_ITEMS) begin
                random_image(mode_items == 0, pushed);
                mode_items += pushed;
            end
        end

        wait_idle();
        $display("covered %0d requests and %0d results over %0d images", req_count,
                 result_count, image_count);
        $display("maps from 1x1 to 40x8 incl. zero width and height, markers 0, all-ones, random");
        if (fail_count == 0) begin
            $display("index_map_hole_dilation verification clean");
        end else begin
            $display("index_map_hole_dilation verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/imhd_pkg.sv
rtl/imhd_ram.sv
rtl/imhd_fill.sv
rtl/index_map_hole_dilation.sv
verif/tb_top.sv
